FILE: sv/ssg_pkg.sv
// ssg_pkg: constants and status codes for the sorted point set block.
// No dependencies; compiled first.
package ssg_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int PCNT_W   = 11;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_ABSENT = 2'd1;
  localparam status_t ST_DUP    = 2'd2;
  localparam status_t ST_FULL   = 2'd3;

  localparam logic CMD_REMOVE = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

endpackage

FILE: sv/ssg_if.sv
// ssg_if: valid/ready channel interfaces for update items and result items.
// Depends on ssg_pkg.
interface ssg_in_if import ssg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [VAL_W-1:0] point_value;

  modport source (output valid, cmd, point_value, input ready);
  modport sink   (input valid, cmd, point_value, output ready);
endinterface

interface ssg_out_if import ssg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [VAL_W-1:0]  cost;
  logic [PCNT_W-1:0] point_count;
  status_t           status;

  modport source (output valid, cost, point_count, status, input ready);
  modport sink   (input valid, cost, point_count, status, output ready);
endinterface

FILE: sv/sorted_set_span_minus_max_gap.sv
// Sorted point set: each item inserts or removes one coordinate; each item yields
// one result: span minus widest neighbor gap, point count and status.
//
// Channels: in_ch (cmd, point_value) and out_ch (cost, point_count, status), both
// valid/ready; an item moves on a clock edge with valid and ready high.
// One item is worked at a time; in_ch.ready is high only while the sequencer idles.
// Steps per item:
//   binary search   a read and a compare per probe, then a check of the landing slot
//   shift           one entry a cycle; an insert then writes the new point
//   gap rescan      one read of the point store per cycle
//   finish          loads the output register
// The time per item is set by the single read port
// of the point store used in both passes.
// The result sits in an output register; the next item is accepted while it
// waits. If out_ch stalls, the finish step waits until the register frees up.
// Reset (rst_n low, synchronous) empties the set and drops any pending result.
// Rejected updates (absent point, duplicate, store full) leave the set as it was.
module sorted_set_span_minus_max_gap import ssg_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  ssg_in_if.sink   in_ch,
  ssg_out_if.source out_ch
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SRCH  = 8'b0000_0010,
    S_SCMP  = 8'b0000_0100,
    S_CHK   = 8'b0000_1000,
    S_SHIFT = 8'b0001_0000,
    S_PUT   = 8'b0010_0000,
    S_SCAN  = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_t;

  state_t            state_r, state_nxt;
  logic              cmd_r, cmd_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic [CNT_W-1:0]  lo_r, lo_nxt;
  logic [CNT_W-1:0]  hi_r, hi_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic [CNT_W-1:0]  held_r, held_nxt;
  logic              pend_r, pend_nxt;
  logic [ADDR_W-1:0] wa_r, wa_nxt;
  status_t           status_r, status_nxt;
  logic [VAL_W-1:0]  first_r, first_nxt;
  logic [VAL_W-1:0]  prev_r, prev_nxt;
  logic [VAL_W-1:0]  widest_r, widest_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]  out_cost_r, out_cost_nxt;
  logic [PCNT_W-1:0] out_count_r, out_count_nxt;
  status_t           out_status_r, out_status_nxt;

  // point store: one write and one registered read per cycle
  logic [VAL_W-1:0]  mem [CAPACITY];
  logic [VAL_W-1:0]  rd_data_r;
  logic [ADDR_W-1:0] rd_addr;
  logic              we;
  logic [ADDR_W-1:0] wr_addr;
  logic [VAL_W-1:0]  wr_data;

  logic [CNT_W-1:0]  mid;
  logic [CNT_W-1:0]  k_inc, k_dec, lo_inc;
  logic [VAL_W-1:0]  gap;
  logic              present;
  logic              in_acc;
  logic              out_free;

  assign mid     = lo_r + ((hi_r - lo_r) >> 1);
  assign k_inc   = k_r + 1'b1;
  assign k_dec   = k_r - 1'b1;
  assign lo_inc  = lo_r + 1'b1;
  assign gap     = rd_data_r - prev_r;
  assign present = (lo_r < held_r) && (rd_data_r == val_r);

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    val_nxt        = val_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    k_nxt          = k_r;
    held_nxt       = held_r;
    pend_nxt       = pend_r;
    wa_nxt         = wa_r;
    status_nxt     = status_r;
    first_nxt      = first_r;
    prev_nxt       = prev_r;
    widest_nxt     = widest_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_cost_nxt   = out_cost_r;
    out_count_nxt  = out_count_r;
    out_status_nxt = out_status_r;
    rd_addr        = lo_r[ADDR_W-1:0];
    we             = 1'b0;
    wr_addr        = wa_r;
    wr_data        = rd_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt    = in_ch.cmd;
          val_nxt    = in_ch.point_value;
          lo_nxt     = '0;
          hi_nxt     = held_r;
          status_nxt = ST_OK;
          state_nxt  = S_SRCH;
        end
      end
      S_SRCH: begin
        if (lo_r < hi_r) begin
          rd_addr   = mid[ADDR_W-1:0];
          state_nxt = S_SCMP;
        end else begin
          // probe the landing slot to see whether the point is held
          rd_addr   = lo_r[ADDR_W-1:0];
          state_nxt = S_CHK;
        end
      end
      S_SCMP: begin
        if (rd_data_r < val_r) begin
          lo_nxt = mid + 1'b1;
        end else begin
          hi_nxt = mid;
        end
        state_nxt = S_SRCH;
      end
      S_CHK: begin
        pend_nxt   = 1'b0;
        k_nxt      = '0;
        widest_nxt = '0;
        state_nxt  = S_SCAN;
        if (cmd_r == CMD_REMOVE) begin
          if (!present) begin
            status_nxt = ST_ABSENT;
          end else begin
            k_nxt     = lo_inc;
            state_nxt = S_SHIFT;
          end
        end else begin
          if (present) begin
            status_nxt = ST_DUP;
          end else if (held_r == CNT_W'(CAPACITY)) begin
            status_nxt = ST_FULL;
          end else begin
            k_nxt     = held_r;
            state_nxt = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        // read ahead one entry, write the entry read the cycle before
        we = pend_r;
        if (cmd_r == CMD_REMOVE) begin
          if (k_r < held_r) begin
            rd_addr  = k_r[ADDR_W-1:0];
            wa_nxt   = k_dec[ADDR_W-1:0];
            pend_nxt = 1'b1;
            k_nxt    = k_inc;
          end else begin
            pend_nxt = 1'b0;
            if (!pend_r) begin
              held_nxt   = held_r - 1'b1;
              k_nxt      = '0;
              widest_nxt = '0;
              state_nxt  = S_SCAN;
            end
          end
        end else begin
          if (k_r > lo_r) begin
            rd_addr  = k_dec[ADDR_W-1:0];
            wa_nxt   = k_r[ADDR_W-1:0];
            pend_nxt = 1'b1;
            k_nxt    = k_dec;
          end else begin
            pend_nxt = 1'b0;
            if (!pend_r) begin
              state_nxt = S_PUT;
            end
          end
        end
      end
      S_PUT: begin
        we         = 1'b1;
        wr_addr    = lo_r[ADDR_W-1:0];
        wr_data    = val_r;
        held_nxt   = held_r + 1'b1;
        k_nxt      = '0;
        pend_nxt   = 1'b0;
        widest_nxt = '0;
        state_nxt  = S_SCAN;
      end
      S_SCAN: begin
        if (k_r < held_r) begin
          rd_addr  = k_r[ADDR_W-1:0];
          k_nxt    = k_inc;
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        // data arriving now belongs to entry k_r-1
        if (pend_r) begin
          prev_nxt = rd_data_r;
          if (k_r == CNT_W'(1)) begin
            first_nxt = rd_data_r;
          end else if (gap > widest_r) begin
            widest_nxt = gap;
          end
        end
        if (!(k_r < held_r) && !pend_r) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_cost_nxt   = (held_r <= CNT_W'(2)) ? '0 : (prev_r - first_r - widest_r);
          out_count_nxt  = PCNT_W'(held_r);
          out_status_nxt = status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      held_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    val_r        <= val_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    k_r          <= k_nxt;
    wa_r         <= wa_nxt;
    status_r     <= status_nxt;
    first_r      <= first_nxt;
    prev_r       <= prev_nxt;
    widest_r     <= widest_nxt;
    out_cost_r   <= out_cost_nxt;
    out_count_r  <= out_count_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.cost        = out_cost_r;
  assign out_ch.point_count = out_count_r;
  assign out_ch.status      = out_status_r;

endmodule

FILE: sv/ssg_chk.sv
// ssg_chk: port-level checks for the sorted point set block, bound to the top.
// Depends on ssg_pkg and the top level sorted_set_span_minus_max_gap.
module ssg_chk import ssg_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [VAL_W-1:0]  out_cost,
  input logic [PCNT_W-1:0] out_point_count,
  input status_t           out_status
);

  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cost) &&
    $stable(out_point_count) && $stable(out_status))
    else $error("result changed or dropped while stalled");

  // one item in flight: ready drops right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while busy");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_point_count <= PCNT_W'(CAPACITY))
    else $error("point count above capacity");

  a_small_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_point_count <= PCNT_W'(2) |-> out_cost == '0)
    else $error("nonzero cost with two or fewer points");

endmodule

bind sorted_set_span_minus_max_gap ssg_chk u_ssg_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_cost        (out_ch.cost),
  .out_point_count (out_ch.point_count),
  .out_status      (out_ch.status)
);
